// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared constants, command and error codes, and ring index arithmetic.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Ring capacity and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    // Command codes.
    typedef enum logic [2:0] {
        CMD_IDLE       = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    // Add an offset below CAPACITY to a ring index, wrapping modulo CAPACITY.
    function automatic idx_t ring_add(input idx_t base, input idx_t offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (IDX_W + 1)'(CAPACITY)) begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of signed 32-bit values kept in a ring buffer RAM.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake       Payload
// command   in         start / busy    command, data_value
// result    out        done (strobe)   front_value, back_value, element_count,
//                                      is_empty, is_full, error_code
//
// The accept cycle updates the pointers and writes a pushed value, the next
// cycle (ST_READ) reads the front and back slots from the RAM, and the
// registered read data is presented in ST_DONE.
// The result shows for one cycle with done high; a new command may be
// accepted in that same cycle, so a new command can start while the last result shows.
// After reset the deque is empty; slot contents need no clearing.
// The result receiver cannot stall the unit.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           command,
    input  deq_pkg::data_t       data_value,
    output logic                 done,
    output deq_pkg::data_t       front_value,
    output deq_pkg::data_t       back_value,
    output deq_pkg::cnt_t        element_count,
    output logic                 is_empty,
    output logic                 is_full,
    output logic [1:0]           error_code
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    idx_t   head_reg, head_next;
    cnt_t   count_reg, count_next;
    err_t   err_reg, err_next;

    logic   accept;
    logic   ram_we;
    idx_t   ram_waddr;
    idx_t   back_addr;
    data_t  rdata_front;
    data_t  rdata_back;
    logic   is_full_now;
    logic   is_empty_now;

    assign busy         = (state_reg == ST_READ);
    assign accept       = start && !busy;
    assign is_full_now  = (count_reg == cnt_t'(CAPACITY));
    assign is_empty_now = (count_reg == '0);

    // Command decode: pointer, count and write updates for an accepted transaction.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        err_next   = err_reg;
        ram_we     = 1'b0;
        ram_waddr  = ring_add(head_reg, count_reg[IDX_W-1:0]);
        if (accept)
        begin
            err_next = ERR_OK;
            unique case (command)
                CMD_PUSH_FRONT:
                begin
                    if (is_full_now)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        head_next  = ring_add(head_reg, idx_t'(CAPACITY - 1));
                        ram_waddr  = head_next;
                        ram_we     = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (is_full_now)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (is_empty_now)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else
                    begin
                        head_next  = ring_add(head_reg, idx_t'(1));
                        count_next = count_reg - cnt_t'(1);
                    end
                end
                CMD_POP_BACK:
                begin
                    if (is_empty_now)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - cnt_t'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: accept, read the end slots, present the result.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = accept ? ST_READ : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            err_reg   <= ERR_OK;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // The rear slot sits count - 1 places past the head.
    assign back_addr = ring_add(head_reg, idx_t'(count_reg - cnt_t'(1)));

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (data_value),
        .raddr_a (head_reg),
        .raddr_b (back_addr),
        .rdata_a (rdata_front),
        .rdata_b (rdata_back)
    );

    // Result ports; the end values read as all ones when the deque is empty.
    assign done          = (state_reg == ST_DONE);
    assign front_value   = is_empty_now ? '1 : rdata_front;
    assign back_value    = is_empty_now ? '1 : rdata_back;
    assign element_count = count_reg;
    assign is_empty      = is_empty_now;
    assign is_full       = is_full_now;
    assign error_code    = err_reg;

endmodule

// ===== rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Watches the top-level ports over time and reports inconsistent behavior.
// ----------------------------------------------------------------------------
module deq_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input deq_pkg::data_t       front_value,
    input deq_pkg::data_t       back_value,
    input deq_pkg::cnt_t        element_count,
    input logic                 is_empty,
    input logic                 is_full
);
    import deq_pkg::*;

    // An accepted transaction keeps the unit busy for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A busy cycle is always followed by a result strobe.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("busy cycle not followed by a result");

    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // Flags agree with the count in every result.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (element_count == '0)) &&
                 (is_full == (element_count == cnt_t'(CAPACITY))))
        else $error("empty or full flag disagrees with the count");

    // An empty deque reports all ones at both ends.
    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> (front_value == '1) && (back_value == '1))
        else $error("empty deque reported an end value other than all ones");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .front_value   (front_value),
    .back_value    (back_value),
    .element_count (element_count),
    .is_empty      (is_empty),
    .is_full       (is_full)
);

// ===== dv/double_ended_queue_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue unit checker
// Watches the command and result channels of the deque unit, keeps a mirror
// of the ring buffer that it updates on every accepted command, and compares
// each result strobe field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [2:0]           command,
    input  deq_pkg::data_t       data_value,
    input  logic                 done,
    input  deq_pkg::data_t       front_value,
    input  deq_pkg::data_t       back_value,
    input  deq_pkg::cnt_t        element_count,
    input  logic                 is_empty,
    input  logic                 is_full,
    input  logic [1:0]           error_code,
    output int                   fail_count,
    output int                   pending_count
);
    import deq_pkg::*;

    typedef struct packed {
        data_t      front;
        data_t      back;
        cnt_t       count;
        logic       empty;
        logic       full;
        logic [1:0] err;
    } deque_status_t;

    // Mirror of the deque state.
    data_t          slot_mirror [CAPACITY];
    int             head_mirror;
    int             count_mirror;
    deque_status_t  expected_status [$];

    // Apply one command to the mirror and return the status it leaves.
    function automatic deque_status_t apply_command(input logic [2:0] cmd, input data_t val);
        deque_status_t st;
        st.err = ERR_OK;
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (count_mirror >= CAPACITY) begin
                    st.err = ERR_FULL;
                end else begin
                    head_mirror = (head_mirror + CAPACITY - 1) % CAPACITY;
                    slot_mirror[head_mirror] = val;
                    count_mirror++;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (count_mirror >= CAPACITY) begin
                    st.err = ERR_FULL;
                end else begin
                    slot_mirror[(head_mirror + count_mirror) % CAPACITY] = val;
                    count_mirror++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (count_mirror == 0) begin
                    st.err = ERR_EMPTY;
                end else begin
                    head_mirror = (head_mirror + 1) % CAPACITY;
                    count_mirror--;
                end
            end
            CMD_POP_BACK:
            begin
                if (count_mirror == 0) begin
                    st.err = ERR_EMPTY;
                end else begin
                    count_mirror--;
                end
            end
            CMD_CLEAR:
            begin
                head_mirror  = 0;
                count_mirror = 0;
            end
            default:
            begin
                // Idle and the unused codes leave the state alone.
            end
        endcase

        // An empty deque shows all ones on both ends.
        if (count_mirror == 0) begin
            st.front = '1;
            st.back  = '1;
        end else begin
            st.front = slot_mirror[head_mirror];
            st.back  = slot_mirror[(head_mirror + count_mirror - 1) % CAPACITY];
        end
        st.count = cnt_t'(count_mirror);
        st.empty = (count_mirror == 0);
        st.full  = (count_mirror >= CAPACITY);
        return st;
    endfunction

    function automatic void report_field(input string field, input logic [31:0] exp_v,
                                         input logic [31:0] act_v);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
        fail_count++;
    endfunction

    // Retire result strobes first, then record the command accepted at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        deque_status_t exp_st;
        if (!rst_n) begin
            head_mirror   = 0;
            count_mirror  = 0;
            fail_count    = 0;
            expected_status.delete();
            pending_count = 0;
        end else begin
            if (done) begin
                if (expected_status.size() == 0) begin
                    $display("%0t ns: result transaction with no command outstanding",
                             $time);
                    fail_count++;
                end else begin
                    exp_st = expected_status[0];
                    expected_status.delete(0);
                    if (front_value !== exp_st.front)
                        report_field("front_value", exp_st.front, front_value);
                    if (back_value !== exp_st.back)
                        report_field("back_value", exp_st.back, back_value);
                    if (element_count !== exp_st.count)
                        report_field("element_count", 32'(exp_st.count), 32'(element_count));
                    if (is_empty !== exp_st.empty)
                        report_field("is_empty", 32'(exp_st.empty), 32'(is_empty));
                    if (is_full !== exp_st.full)
                        report_field("is_full", 32'(exp_st.full), 32'(is_full));
                    if (error_code !== exp_st.err)
                        report_field("error_code", 32'(exp_st.err), 32'(error_code));
                end
            end
            if (start && !busy) begin
                expected_status.insert(expected_status.size(),
                                       apply_command(command, data_value));
            end
            pending_count = expected_status.size();
        end
    end

endmodule

// ===== dv/double_ended_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives directed corner commands and then phases of push-heavy, pop-heavy
// and mixed random commands with random gaps into the deque unit. A separate
// checker predicts every result and counts mismatches; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;
    import deq_pkg::*;

    localparam int          RANDOM_ITEMS = 850;
    localparam int          CYCLE_LIMIT  = 200000;
    // Command codes the unit treats as idle.
    localparam logic [2:0]  CMD_SPARE_A  = 3'd6;
    localparam logic [2:0]  CMD_SPARE_B  = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [2:0]   command;
    data_t        data_value;
    logic         done;
    data_t        front_value;
    data_t        back_value;
    cnt_t         element_count;
    logic         is_empty;
    logic         is_full;
    logic [1:0]   error_code;
    int           fail_count;
    int           pending_count;
    int           cycle_count = 0;

    double_ended_queue_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .data_value    (data_value),
        .done          (done),
        .front_value   (front_value),
        .back_value    (back_value),
        .element_count (element_count),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .error_code    (error_code)
    );

    double_ended_queue_unit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .data_value    (data_value),
        .done          (done),
        .front_value   (front_value),
        .back_value    (back_value),
        .element_count (element_count),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .error_code    (error_code),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog on the run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("double_ended_queue_unit_tb: done, errors");
            $finish;
        end
    end

    // Present one command and hold it until the unit takes the transaction.
    task automatic issue(input logic [2:0] cmd, input data_t val);
        logic busy_seen;
        start      <= 1'b1;
        command    <= cmd;
        data_value <= val;
        do begin
            @(negedge clk);
            busy_seen = busy;
            @(posedge clk);
        end while (busy_seen);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        @(posedge clk);
    endtask

    // Mostly random words, with the extremes mixed in.
    function automatic data_t pick_value();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_idle_code();
        case ($urandom_range(2))
            0:       return CMD_IDLE;
            1:       return CMD_SPARE_A;
            default: return CMD_SPARE_B;
        endcase
    endfunction

    // Command mix per phase: thresholds for push front, push back,
    // pop front, pop back and idle; the rest clears.
    function automatic logic [2:0] pick_command(input int mode);
        int roll;
        int t_pf;
        int t_pb;
        int t_qf;
        int t_qb;
        int t_id;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:  begin t_pf = 38; t_pb = 74; t_qf = 84; t_qb = 93; t_id = 98; end
            MODE_DRAIN: begin t_pf = 12; t_pb = 25; t_qf = 59; t_qb = 93; t_id = 98; end
            default:    begin t_pf = 22; t_pb = 45; t_qf = 67; t_qb = 90; t_id = 98; end
        endcase
        if (roll < t_pf) return CMD_PUSH_FRONT;
        if (roll < t_pb) return CMD_PUSH_BACK;
        if (roll < t_qf) return CMD_POP_FRONT;
        if (roll < t_qb) return CMD_POP_BACK;
        if (roll < t_id) return pick_idle_code();
        return CMD_CLEAR;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int mode;
        int phase_left;
        logic quiet;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        command    <= CMD_IDLE;
        data_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque: idle, both pops, and the unused codes.
        issue(CMD_IDLE, 32'h1234_5678);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_BACK, '1);
        issue(CMD_SPARE_A, 32'hA5A5_A5A5);
        issue(CMD_SPARE_B, 32'h5A5A_5A5A);

        // Fill from both ends, wrapping the head below zero, with extreme values.
        issue(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        issue(CMD_PUSH_BACK, 32'h8000_0000);
        issue(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        issue(CMD_PUSH_BACK, 32'h0000_0000);
        for (int i = 4; i < CAPACITY; i++) begin
            issue((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        end

        // Full deque: both pushes are refused, then idle, both pops and a clear.
        issue(CMD_PUSH_FRONT, 32'hDEAD_0001);
        issue(CMD_PUSH_BACK, 32'hDEAD_0002);
        issue(CMD_IDLE, '0);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_BACK, '0);
        issue(CMD_CLEAR, 32'hFFFF_FFFF);

        wait_drained();

        // Random phases of filling, draining and mixed traffic.
        mode       = MODE_FILL;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                mode       = $urandom_range(2);
                phase_left = $urandom_range(10, 40);
            end
            phase_left--;
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            // A long stretch runs back to back.
            quiet = (n >= 200 && n < 400);
            if (!quiet && $urandom_range(99) < 38) begin
                idle_gap($urandom_range(1, 3));
            end
            issue(pick_command(mode), pick_value());
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("double_ended_queue_unit_tb: done, clean");
        end else begin
            $display("double_ended_queue_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== double_ended_queue_unit.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue_unit.sv
rtl/deq_checker.sv
dv/double_ended_queue_unit_checker.sv
dv/double_ended_queue_unit_tb.sv
